### hw/rtl/aescm_pkg.sv
// Shared AES-128 types, tables and round functions for the CMAC unit.
`default_nettype none
package aescm_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [10:0][127:0] rkeys_t;

  localparam int NumRounds = 10;
  localparam logic [4:0] FullCount = 5'd16;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] ReduceByte = 8'h87;
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply a byte by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Expand the cipher key into all round keys.
  function automatic rkeys_t key_expand(input blk_t key);
    rkeys_t rk;
    logic [7:0] rc;
    logic [31:0] temp, w0, w1, w2, w3, last;
    rk[0] = key;
    rc = 8'h01;
    for (int r = 1; r <= NumRounds; r++) begin
      last = rk[r-1][31:0];
      temp = {SBOX[last[23:16]] ^ rc, SBOX[last[15:8]], SBOX[last[7:0]], SBOX[last[31:24]]};
      w0 = rk[r-1][127:96] ^ temp;
      w1 = rk[r-1][95:64] ^ w0;
      w2 = rk[r-1][63:32] ^ w1;
      w3 = rk[r-1][31:0] ^ w2;
      rk[r] = {w0, w1, w2, w3};
      rc = xtime(rc);
    end
    return rk;
  endfunction

  // One cipher round: sub bytes, shift rows, optional mix columns, add key.
  function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last_round);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8*(c*4+i) -: 8] = SBOX[s[127 - 8*((((c+i) % 4)*4)+i) -: 8]];
      end
    end
    if (!last_round) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[127 - 8*(c*4) -: 8];
        a1 = t[127 - 8*(c*4+1) -: 8];
        a2 = t[127 - 8*(c*4+2) -: 8];
        a3 = t[127 - 8*(c*4+3) -: 8];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[127 - 8*(c*4) -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
        t[127 - 8*(c*4+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
        t[127 - 8*(c*4+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
        t[127 - 8*(c*4+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

  // Full AES-128 encryption with pre-expanded round keys.
  function automatic blk_t aes_encrypt(input blk_t din, input rkeys_t rk);
    blk_t s;
    s = din ^ rk[0];
    for (int r = 1; r <= NumRounds; r++) begin
      s = aes_round(s, rk[r], r == NumRounds);
    end
    return s;
  endfunction

  // Multiply a block by x in GF(2^128).
  function automatic blk_t gf_double(input blk_t v);
    return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, ReduceByte} : 128'd0);
  endfunction

  // Keep the first count bytes, place the pad marker, zero the rest.
  function automatic blk_t pad_block(input blk_t v, input logic [3:0] count);
    blk_t p;
    for (int i = 0; i < 16; i++) begin
      if (i < int'(count)) p[127 - 8*i -: 8] = v[127 - 8*i -: 8];
      else if (i == int'(count)) p[127 - 8*i -: 8] = PadByte;
      else p[127 - 8*i -: 8] = 8'h00;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/aes_cmac_128_unit.sv
// AES-128 CMAC unit: one 16-byte message block per cycle while not stalled, tag on the final block.
//
// Usage:
//   Write the key over the configuration channel (index 0 = key bytes 0..7,
//   index 1 = key bytes 8..15); cfg_ready is always high. Write only while idle.
//   Feed message blocks on the input channel (in_valid / in_stall). Non-final
//   blocks carry 16 bytes; the final block carries 0..16 bytes. A short
//   non-final block is not chained and flags length_error on the tag.
//   One tag transaction leaves on the output channel per final block.
// Timing:
//   A block is registered at acceptance and fully encrypted from that register
//   by an unrolled ten-round AES datapath; the tag is registered when its final
//   block leaves the input register, and can leave from the output register.
//   One block per cycle is sustained while the input is not stalled, set by the
//   chaining loop through the unrolled rounds. Subkeys derive from the registered subkey_l.
// Reset: clears chaining state, error flag, key and both valid flags.
// Stall: a held tag blocks the next final block in the input register, which
//   then stalls the input; non-final blocks keep flowing.
`default_nettype none
module aes_cmac_128_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] data_high,
  input  wire logic [63:0] data_low,
  input  wire logic [4:0]  byte_count,
  input  wire logic        final_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      tag_high,
  output logic [63:0]      tag_low,
  output logic             length_error
);

  logic [127:0] key;
  logic [127:0] subkey_l;
  aescm_pkg::rkeys_t round_keys;

  logic         s1_valid;
  logic [127:0] s1_data;
  logic [4:0]   s1_count;
  logic         s1_final;

  logic [127:0] chain;
  logic         short_seen;

  logic         advance;
  logic         s1_full;
  logic [127:0] k1, k2, final_in, cipher_in, cipher_out;

  assign cfg_ready = 1'b1;
  assign round_keys = aescm_pkg::key_expand(key);

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if ({1'b0, cfg_index} == aescm_pkg::RegKeyHigh) key[127:64] <= cfg_data;
      else key[63:0] <= cfg_data;
    end
  end

  // Hold the encryption of zero under the current key
  always_ff @(posedge clk) begin
    subkey_l <= aescm_pkg::aes_encrypt('0, round_keys);
  end

  // Advance the input register unless a tag would collide with a held one
  assign advance = s1_valid && (!s1_final || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
      s1_data  <= {data_high, data_low};
      s1_count <= byte_count;
      s1_final <= final_block;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Build the cipher input: chained block or masked final block
  assign s1_full = s1_count[4];
  assign k1 = aescm_pkg::gf_double(subkey_l);
  assign k2 = aescm_pkg::gf_double(k1);
  assign final_in = s1_full ? (s1_data ^ k1)
                            : (aescm_pkg::pad_block(s1_data, s1_count[3:0]) ^ k2);
  assign cipher_in = (s1_final ? final_in : s1_data) ^ chain;
  assign cipher_out = aescm_pkg::aes_encrypt(cipher_in, round_keys);

  // Update chaining state; counts above sixteen count as full
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
      short_seen <= 1'b0;
    end else if (advance) begin
      if (s1_final) begin
        chain <= '0;
        short_seen <= 1'b0;
      end else if (!s1_full) begin
        short_seen <= 1'b1;
      end else begin
        chain <= cipher_out;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_final) begin
      out_valid    <= 1'b1;
      tag_high     <= cipher_out[127:64];
      tag_low      <= cipher_out[63:0];
      length_error <= short_seen;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A stall on the input only comes from a blocked tag
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_final && out_valid && out_stall))
    else $error("input stalled without a blocked tag");

  // End of message clears the chaining state
  a_msg_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_final) |=> (chain == '0 && !short_seen))
    else $error("chaining state not cleared after final block");

  // A new tag only follows a final block leaving the input register
  a_tag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && s1_final))
    else $error("tag without a final block");

  // A short non-final block never changes the chaining value
  a_short_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && !s1_final && !s1_full) |=> $stable(chain))
    else $error("short block was chained");

endmodule
`default_nettype wire
